FILE: rtl/lzd_pkg.sv
// Shared types and constants for the LZ77 window decoder.
`default_nettype none
package lzd_pkg;

   localparam int OFFSET_W   = 13;
   localparam int LEN_W      = 4;
   localparam int BYTE_W     = 8;
   localparam int HIST_AW    = 12;
   localparam int HIST_DEPTH = 1 << HIST_AW;
   localparam int FILL_W     = HIST_AW + 1;
   localparam int MAX_MATCH  = 15;
   localparam int QUEUE_AW   = 1;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   typedef struct packed {
      logic [HIST_AW-1:0] back;
      logic [LEN_W-1:0]   copy_len;
      logic [BYTE_W-1:0]  literal;
      logic               bad;
   } cmd_type;

endpackage : lzd_pkg
`default_nettype wire

FILE: rtl/lzd_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module lzd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : lzd_ram
`default_nettype wire

FILE: rtl/lzd_front.sv
// Front end: accepts triples, classifies them and queues commands for the back end.
`default_nettype none
module lzd_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [lzd_pkg::OFFSET_W-1:0]     req_offset,
   input  wire logic [lzd_pkg::LEN_W-1:0]        req_match_length,
   input  wire logic [lzd_pkg::BYTE_W-1:0]       req_literal,
   output logic                                  head_valid,
   output lzd_pkg::cmd_type                      head,
   input  wire logic                             pop
);
   import lzd_pkg::*;

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                push;
   logic [LEN_W-1:0]    len_sat;
   cmd_type             cmd;

   always_comb begin
      if (req_match_length > LEN_W'(MAX_MATCH)) begin
         len_sat = LEN_W'(MAX_MATCH);
      end else begin
         len_sat = req_match_length;
      end
      cmd.back    = req_offset[HIST_AW-1:0];
      cmd.literal = req_literal;
      cmd.bad     = (req_offset == '0) && (len_sat != '0);
      cmd.copy_len = (req_offset == '0) ? '0 : len_sat;
   end

   assign req_stall  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule : lzd_front
`default_nettype wire

FILE: rtl/lzd_back.sv
// Back end: sequences copy and literal bytes through the history RAM to the output register.
`default_nettype none
module lzd_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         head_valid,
   input  lzd_pkg::cmd_type                  head,
   output logic                              pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [lzd_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                              rsp_last,
   output logic                              rsp_bad_reference
);
   import lzd_pkg::*;

   // issue pointer, fill count and copy index
   logic [HIST_AW-1:0] wp_ff, wp_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [LEN_W-1:0]   k_ff, k_in;

   // pending stage, waiting on RAM data
   logic               p_valid_ff, p_valid_in;
   logic               p_is_lit_ff;
   logic               p_zero_ff;
   logic               p_hit_ff;
   logic               p_bad_ff;
   logic [BYTE_W-1:0]  p_lit_ff;
   logic [BYTE_W-1:0]  p_fwd_ff;
   logic [HIST_AW-1:0] p_addr_ff;

   // output register
   logic               o_valid_ff, o_valid_in;
   logic [BYTE_W-1:0]  o_byte_ff;
   logic               o_last_ff;
   logic               o_bad_ff;

   logic               o_free;
   logic               p_move;
   logic               issue;
   logic               is_copy;
   logic [HIST_AW-1:0] rd_addr;
   logic [FILL_W-1:0]  back_eff;
   logic               zero_in;
   logic               hit_in;
   logic [BYTE_W-1:0]  ram_q;
   logic [BYTE_W-1:0]  p_data;

   assign o_free  = !o_valid_ff || !rsp_stall;
   assign p_move  = p_valid_ff && o_free;
   assign issue   = head_valid && (!p_valid_ff || p_move);
   assign is_copy = (k_ff < head.copy_len);
   assign pop     = issue && !is_copy;
   assign rd_addr = wp_ff - head.back;
   assign back_eff = {(head.back == '0), head.back};
   assign zero_in  = (back_eff > fill_ff);
   assign hit_in   = p_move && (p_addr_ff == rd_addr);

   always_comb begin
      priority if (p_is_lit_ff) begin
         p_data = p_lit_ff;
      end else if (p_zero_ff) begin
         p_data = '0;
      end else if (p_hit_ff) begin
         p_data = p_fwd_ff;
      end else begin
         p_data = ram_q;
      end
   end

   lzd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (HIST_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (p_move),
      .wr_addr (p_addr_ff),
      .wr_data (p_data),
      .rd_en   (issue && is_copy),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      wp_in      = wp_ff;
      fill_in    = fill_ff;
      k_in       = k_ff;
      p_valid_in = p_valid_ff;
      o_valid_in = o_valid_ff;
      if (issue) begin
         wp_in      = wp_ff + 1'b1;
         p_valid_in = 1'b1;
         if (fill_ff != FILL_W'(HIST_DEPTH)) begin
            fill_in = fill_ff + 1'b1;
         end
         if (is_copy) begin
            k_in = k_ff + 1'b1;
         end else begin
            k_in = '0;
         end
      end else if (p_move) begin
         p_valid_in = 1'b0;
      end
      if (p_move) begin
         o_valid_in = 1'b1;
      end else if (o_valid_ff && !rsp_stall) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         fill_ff    <= '0;
         k_ff       <= '0;
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         fill_ff    <= fill_in;
         k_ff       <= k_in;
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         p_is_lit_ff <= !is_copy;
         p_zero_ff   <= zero_in;
         p_hit_ff    <= hit_in;
         p_fwd_ff    <= p_data;
         p_bad_ff    <= head.bad;
         p_lit_ff    <= head.literal;
         p_addr_ff   <= wp_ff;
      end
      if (p_move) begin
         o_byte_ff <= p_data;
         o_last_ff <= p_is_lit_ff;
         o_bad_ff  <= p_is_lit_ff && p_bad_ff;
      end
   end

   assign rsp_valid         = o_valid_ff;
   assign rsp_out_byte      = o_byte_ff;
   assign rsp_last          = o_last_ff;
   assign rsp_bad_reference = o_bad_ff;

endmodule : lzd_back
`default_nettype wire

FILE: rtl/lz77_window_decoder_top.sv
// Top level of the LZ77 window decoder: front-end queue feeding the history back end.
// An accepted triple passes the front-end queue, pending stage and output register
// before its first byte reaches rsp. Throughput: one output byte per cycle while
// commands are queued and rsp_stall is low; a triple yields its copied bytes plus
// its literal byte (1 to 16, offset zero copies nothing) via the one history read port.
// Reset: synchronous; clears pointers, queue and fill count, no clearing pass of the
// 4096-byte history: positions not yet written read as zero. Ready right after reset.
`default_nettype none
module lz77_window_decoder_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [lzd_pkg::OFFSET_W-1:0] req_offset,
   input  wire logic [lzd_pkg::LEN_W-1:0]    req_match_length,
   input  wire logic [lzd_pkg::BYTE_W-1:0]   req_literal,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [lzd_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                              rsp_last,
   output logic                              rsp_bad_reference
);
   import lzd_pkg::*;

   logic    head_valid;
   cmd_type head;
   logic    pop;

   lzd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_offset       (req_offset),
      .req_match_length (req_match_length),
      .req_literal      (req_literal),
      .head_valid       (head_valid),
      .head             (head),
      .pop              (pop)
   );

   lzd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last          (rsp_last),
      .rsp_bad_reference (rsp_bad_reference)
   );

endmodule : lz77_window_decoder_top
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the LZ77 window decoder: directed and random triples.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lzd_pkg::*;

   localparam int DIRECTED_ITEMS = 16;
   localparam int RANDOM_ITEMS   = 194;
   localparam int IDLE_PCT       = 33;
   localparam int STEADY_FROM    = 80;
   localparam int STEADY_TO      = 130;
   localparam int DRAIN_CYCLES   = 32;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int REPORT_MAX     = 10;

   typedef struct {
      logic [OFFSET_W-1:0] offset;
      logic [LEN_W-1:0]    match_length;
      logic [BYTE_W-1:0]   literal;
   } triple_type;

   typedef struct {
      logic [BYTE_W-1:0] out_byte;
      logic              last;
      logic              bad_reference;
   } decoded_byte_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OFFSET_W-1:0] req_offset = '0;
   logic [LEN_W-1:0]    req_match_length = '0;
   logic [BYTE_W-1:0]   req_literal = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_last;
   logic                rsp_bad_reference;

   triple_type       triple_queue[$];
   decoded_byte_type expected_bytes[$];
   logic [BYTE_W-1:0]  window_copy[HIST_DEPTH];
   logic [HIST_AW-1:0] window_wp;
   logic               req_taken;
   int                 total_triples;
   int                 accepted_triples;
   int                 mismatches;
   int                 cycle_count;
   logic               steady;

   lz77_window_decoder_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_offset        (req_offset),
      .req_match_length  (req_match_length),
      .req_literal       (req_literal),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last          (rsp_last),
      .rsp_bad_reference (rsp_bad_reference)
   );

   always #2 clock = ~clock;

   assign steady = accepted_triples >= STEADY_FROM && accepted_triples < STEADY_TO;

   task automatic push_expected(input logic [BYTE_W-1:0] b, input logic last,
                                input logic bad);
      decoded_byte_type e;
      e.out_byte      = b;
      e.last          = last;
      e.bad_reference = bad;
      expected_bytes.insert(expected_bytes.size(), e);
      window_copy[window_wp] = b;
      window_wp++;
   endtask

   task automatic decode_triple(input logic [OFFSET_W-1:0] off,
                                input logic [LEN_W-1:0] len,
                                input logic [BYTE_W-1:0] lit);
      logic [HIST_AW-1:0] back;
      logic [HIST_AW-1:0] rd_ptr;
      int                 copy_count;
      copy_count = (len > MAX_MATCH) ? MAX_MATCH : int'(len);
      back = off[HIST_AW-1:0];
      if (off != '0) begin
         for (int i = 0; i < copy_count; i++) begin
            rd_ptr = window_wp - back;
            push_expected(window_copy[rd_ptr], 1'b0, 1'b0);
         end
      end
      push_expected(lit, 1'b1, off == '0 && copy_count != 0);
   endtask

   function automatic triple_type make_triple(input int off, input int len, input int lit);
      triple_type t;
      t.offset       = off[OFFSET_W-1:0];
      t.match_length = len[LEN_W-1:0];
      t.literal      = lit[BYTE_W-1:0];
      return t;
   endfunction

   function automatic triple_type random_triple();
      int pick;
      int off;
      pick = $urandom_range(99);
      if (pick < 8)
         off = 0;
      else if (pick < 70)
         off = $urandom_range(32, 1);
      else if (pick < 85)
         off = $urandom_range(HIST_DEPTH - 1, 1);
      else if (pick < 95)
         off = $urandom_range((1 << OFFSET_W) - 1, HIST_DEPTH);
      else
         off = ($urandom_range(1) == 0) ? HIST_DEPTH : (1 << OFFSET_W) - 1;
      return make_triple(off, $urandom_range(15), $urandom_range(255));
   endfunction

   task automatic queue_triple(input int off, input int len, input int lit);
      triple_queue.insert(triple_queue.size(), make_triple(off, len, lit));
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
         if (!(req_valid && !req_taken)) begin
            if (triple_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               req_valid        <= 1'b1;
               req_offset       <= triple_queue[0].offset;
               req_match_length <= triple_queue[0].match_length;
               req_literal      <= triple_queue[0].literal;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      decoded_byte_type e;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            decode_triple(req_offset, req_match_length, req_literal);
            void'(triple_queue.pop_front());
            accepted_triples <= accepted_triples + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               if (mismatches < REPORT_MAX)
                  $display("unexpected transaction at cycle %0d: byte %02h last %0b bad %0b",
                           cycle_count, rsp_out_byte, rsp_last, rsp_bad_reference);
               mismatches <= mismatches + 1;
            end else begin
               e = expected_bytes.pop_front();
               if (rsp_out_byte !== e.out_byte || rsp_last !== e.last ||
                   rsp_bad_reference !== e.bad_reference) begin
                  if (mismatches < REPORT_MAX)
                     $display("mismatch at cycle %0d: expected %02h/%0b/%0b got %02h/%0b/%0b",
                              cycle_count, e.out_byte, e.last, e.bad_reference,
                              rsp_out_byte, rsp_last, rsp_bad_reference);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

   initial begin
      window_wp        = '0;
      req_taken        = 1'b0;
      accepted_triples = 0;
      mismatches       = 0;
      cycle_count      = 0;
      for (int i = 0; i < HIST_DEPTH; i++)
         window_copy[i] = '0;

      queue_triple(100, 4, 'h11);
      queue_triple(0, 0, 'h00);
      queue_triple(0, 5, 'hFF);
      queue_triple(0, 15, 'h01);
      queue_triple(1, 15, 'hA5);
      queue_triple(3, 10, 'h5A);
      queue_triple(2, 0, 'h80);
      queue_triple(HIST_DEPTH, 3, 'h33);
      queue_triple((1 << OFFSET_W) - 1, 15, 'hC3);
      queue_triple(HIST_DEPTH + 1, 2, 'h7E);
      queue_triple(5000, 7, 'h42);
      queue_triple(HIST_DEPTH - 1, 15, 'h3C);
      queue_triple(12, 12, 'h96);
      queue_triple(40, 1, 'h69);
      queue_triple(1, 1, 'hFE);
      queue_triple(2 * HIST_DEPTH - 2, 6, 'h0F);
      for (int i = 0; i < RANDOM_ITEMS; i++)
         triple_queue.insert(triple_queue.size(), random_triple());
      total_triples = DIRECTED_ITEMS + RANDOM_ITEMS;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_triples < total_triples)
         @(posedge clock);
      while (expected_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);

      if (mismatches == 0 && expected_bytes.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule : testbench
`default_nettype wire

FILE: sim.f
rtl/lzd_pkg.sv
rtl/lzd_ram.sv
rtl/lzd_front.sv
rtl/lzd_back.sv
rtl/lz77_window_decoder_top.sv
dv/testbench.sv
